// ===== sv/gbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbp_pkg
// Types and codes shared by the grid broad-phase collision block.
// ----------------------------------------------------------------------------
package gbp_pkg;

  // command codes
  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdCheck  = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  // result status codes
  localparam logic [2:0] StatInserted = 3'd0;
  localparam logic [2:0] StatOutside  = 3'd1;
  localparam logic [2:0] StatFull     = 3'd2;
  localparam logic [2:0] StatCleared  = 3'd3;
  localparam logic [2:0] StatPair     = 3'd4;
  localparam logic [2:0] StatBadIndex = 3'd5;

  // configuration register indexes
  localparam logic RegAreaWidth  = 1'b0;
  localparam logic RegAreaHeight = 1'b1;

  localparam logic [14:0] AreaWidthRst  = 15'd800;
  localparam logic [14:0] AreaHeightRst = 15'd600;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } box_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] body_x;
    logic signed [15:0] body_y;
    logic [14:0]        body_w;
    logic [14:0]        body_h;
    logic signed [15:0] sight_x;
    logic signed [15:0] sight_y;
    logic [14:0]        sight_w;
    logic [14:0]        sight_h;
    logic               has_sight;
    logic [1:0]         cell_sel;
    logic [3:0]         entry_sel;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] placed_cell;
    logic [3:0] placed_index;
    logic [3:0] other_index;
    logic       pair_valid;
    logic       body_hit;
    logic       sight_hit;
    logic       last;
  } res_t;

endpackage

// ===== sv/grid_broad_phase_collision_top.sv =====
// ----------------------------------------------------------------------------
// grid_broad_phase_collision_top
// 2x2 uniform-grid broad phase: insert boxes into cells, check one entry
// against the rest of its cell, clear all cells.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------
//  command   | start_i / busy_o          | item_i   (item_t)
//  result    | result_valid_o (strobe)   | result_o (res_t)
//  config    | cfg_we_i, cfg_idx_i       | cfg_data_i
//
// Insert, clear and refused checks leave busy_o low; the result follows on
// the next cycle. A check that walks its cell holds busy_o high while it
// reads its own entry and then the bodies of the cell one by one, giving
// one pair result per other entry; the next item is taken once busy_o falls.
// Reset empties all cells at once; there is no clearing pass.
// Results cannot be held off by the receiver.
module grid_broad_phase_collision_top #(
  parameter int unsigned ENTRIES_PER_CELL = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  gbp_pkg::item_t  item_i,
  output logic            result_valid_o,
  output gbp_pkg::res_t   result_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [14:0]     cfg_data_i
);

  localparam int unsigned Depth = 4 * ENTRIES_PER_CELL;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(ENTRIES_PER_CELL + 1);
  localparam int unsigned SW    = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] Full = CW'(ENTRIES_PER_CELL);
  localparam logic [AW-1:0] Span = AW'(ENTRIES_PER_CELL);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLoad = 2'd1;
  localparam logic [1:0] StRun  = 2'd2;

  typedef struct packed {
    logic          has;
    gbp_pkg::box_t box;
  } sight_ent_t;

  // storage
  gbp_pkg::box_t body_mem  [Depth];
  sight_ent_t    sight_mem [Depth];
  gbp_pkg::box_t body_rd_q;
  sight_ent_t    sight_rd_q;

  logic [CW-1:0] cnt_q [4];
  logic [14:0]   aw_q, ah_q;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] base_q;
  logic [CW-1:0] n_q, idx_q, rd_idx_q, last_idx_q;
  logic [3:0]    sel_q;
  logic [1:0]    cell_q;
  logic          rd_vld_q;
  gbp_pkg::box_t mine_q;
  sight_ent_t    my_sight_q;

  logic          res_valid_q, res_valid_d;
  gbp_pkg::res_t res_q, res_d;

  logic accept, is_ins, is_chk, is_clr;
  assign busy_o = (state_q != StIdle);
  assign accept = start_i & ~busy_o;
  assign is_ins = accept && (item_i.cmd == gbp_pkg::CmdInsert);
  assign is_chk = accept && (item_i.cmd == gbp_pkg::CmdCheck);
  assign is_clr = accept && (item_i.cmd == gbp_pkg::CmdClear);

  // insert: cell of the top-left corner
  logic          in_area, col, row, ins_full, ins_wr;
  logic [13:0]   half_w, half_h;
  logic [1:0]    ins_cell;
  logic [CW-1:0] ins_n;
  logic [AW-1:0] ins_addr;

  assign in_area = ~item_i.body_x[15] & ~item_i.body_y[15] &
                   (item_i.body_x[14:0] < aw_q) & (item_i.body_y[14:0] < ah_q);
  assign half_w   = (aw_q[14:1] == 14'd0) ? 14'd1 : aw_q[14:1];
  assign half_h   = (ah_q[14:1] == 14'd0) ? 14'd1 : ah_q[14:1];
  assign col      = item_i.body_x[14:0] >= {1'b0, half_w};
  assign row      = item_i.body_y[14:0] >= {1'b0, half_h};
  assign ins_cell = {col, row};
  assign ins_n    = cnt_q[ins_cell];
  assign ins_full = (ins_n == Full);
  assign ins_wr   = is_ins & in_area & ~ins_full;
  assign ins_addr = AW'(ins_cell) * Span + AW'(ins_n);

  // check: selection against the cell count
  logic [CW-1:0] chk_n;
  logic [SW-1:0] sel_ext, n_ext;
  logic          chk_bad, chk_alone, chk_go;
  logic [AW-1:0] chk_base;
  logic [CW-1:0] chk_last;

  assign chk_n     = cnt_q[item_i.cell_sel];
  assign sel_ext   = SW'(item_i.entry_sel);
  assign n_ext     = SW'(chk_n);
  assign chk_bad   = (sel_ext >= n_ext);
  assign chk_alone = (chk_n == CW'(1));
  assign chk_go    = is_chk & ~chk_bad & ~chk_alone;
  assign chk_base  = AW'(item_i.cell_sel) * Span;
  assign chk_last  = (sel_ext == n_ext - SW'(1)) ? chk_n - CW'(2) : chk_n - CW'(1);

  // walk: one body read per cycle
  logic          issue, skip, rd_en, emit_last;
  logic [AW-1:0] rd_addr;

  assign issue     = (idx_q < n_q);
  assign skip      = (SW'(idx_q) == SW'(sel_q));
  assign rd_en     = chk_go | (busy_o & issue);
  assign rd_addr   = busy_o ? base_q + AW'(idx_q) : chk_base + AW'(item_i.entry_sel);
  assign emit_last = rd_vld_q && (rd_idx_q == last_idx_q);

  always_ff @(posedge clk_i) begin
    if (ins_wr) begin
      body_mem[ins_addr]  <= '{x: item_i.body_x, y: item_i.body_y,
                               w: item_i.body_w, h: item_i.body_h};
      sight_mem[ins_addr] <= '{has: item_i.has_sight,
                               box: '{x: item_i.sight_x, y: item_i.sight_y,
                                      w: item_i.sight_w, h: item_i.sight_h}};
    end
    if (rd_en) begin
      body_rd_q  <= body_mem[rd_addr];
      sight_rd_q <= sight_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 4; c++) cnt_q[c] <= '0;
    end else if (is_clr) begin
      for (int c = 0; c < 4; c++) cnt_q[c] <= '0;
    end else if (ins_wr) begin
      cnt_q[ins_cell] <= ins_n + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q <= gbp_pkg::AreaWidthRst;
      ah_q <= gbp_pkg::AreaHeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gbp_pkg::RegAreaWidth:  aw_q <= cfg_data_i;
        gbp_pkg::RegAreaHeight: ah_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (chk_go) state_d = StLoad;
      StLoad:  state_d = StRun;
      StRun:   if (emit_last) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  logic pair_bh, pair_sh;

  gbp_pair_cmp u_cmp (
    .mine_i      (mine_q),
    .sight_i     (my_sight_q.box),
    .has_sight_i (my_sight_q.has),
    .other_i     (body_rd_q),
    .body_hit_o  (pair_bh),
    .sight_hit_o (pair_sh)
  );

  always_comb begin
    res_valid_d = 1'b0;
    res_d       = '0;
    res_d.last  = 1'b1;
    if (busy_o) begin
      if (state_q == StRun && rd_vld_q) begin
        res_valid_d        = 1'b1;
        res_d.status       = gbp_pkg::StatPair;
        res_d.placed_cell  = cell_q;
        res_d.placed_index = sel_q;
        res_d.other_index  = 4'(rd_idx_q);
        res_d.pair_valid   = 1'b1;
        res_d.body_hit     = pair_bh;
        res_d.sight_hit    = pair_sh;
        res_d.last         = emit_last;
      end
    end else if (is_ins) begin
      res_valid_d = 1'b1;
      if (!in_area) begin
        res_d.status = gbp_pkg::StatOutside;
      end else if (ins_full) begin
        res_d.status      = gbp_pkg::StatFull;
        res_d.placed_cell = ins_cell;
      end else begin
        res_d.status       = gbp_pkg::StatInserted;
        res_d.placed_cell  = ins_cell;
        res_d.placed_index = 4'(ins_n);
      end
    end else if (is_clr) begin
      res_valid_d  = 1'b1;
      res_d.status = gbp_pkg::StatCleared;
    end else if (is_chk && (chk_bad || chk_alone)) begin
      res_valid_d        = 1'b1;
      res_d.status       = chk_bad ? gbp_pkg::StatBadIndex : gbp_pkg::StatPair;
      res_d.placed_cell  = item_i.cell_sel;
      res_d.placed_index = item_i.entry_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rd_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      // the own entry is read but never compared with itself
      rd_vld_q    <= busy_o && issue && !skip && !emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (chk_go) begin
      base_q     <= chk_base;
      n_q        <= chk_n;
      sel_q      <= item_i.entry_sel;
      cell_q     <= item_i.cell_sel;
      last_idx_q <= chk_last;
      idx_q      <= '0;
    end else if (busy_o && issue) begin
      idx_q <= idx_q + CW'(1);
    end
    if (state_q == StLoad) begin
      mine_q     <= body_rd_q;
      my_sight_q <= sight_rd_q;
    end
    if (busy_o) rd_idx_q <= idx_q;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ===== sv/gbp_pair_cmp.sv =====
// ----------------------------------------------------------------------------
// gbp_pair_cmp
// Strict-overlap box tests of one stored entry against another body.
// ----------------------------------------------------------------------------
module gbp_pair_cmp (
  input  gbp_pkg::box_t mine_i,
  input  gbp_pkg::box_t sight_i,
  input  logic          has_sight_i,
  input  gbp_pkg::box_t other_i,
  output logic          body_hit_o,
  output logic          sight_hit_o
);

  function automatic logic overlap(gbp_pkg::box_t a, gbp_pkg::box_t b);
    logic signed [16:0] ax, ay, bx, by, ar, ab, br, bb;
    ax = {a.x[15], a.x};
    ay = {a.y[15], a.y};
    bx = {b.x[15], b.x};
    by = {b.y[15], b.y};
    ar = ax + $signed({2'b00, a.w});
    ab = ay + $signed({2'b00, a.h});
    br = bx + $signed({2'b00, b.w});
    bb = by + $signed({2'b00, b.h});
    return (ax < br) && (ar > bx) && (ay < bb) && (ab > by);
  endfunction

  assign body_hit_o  = overlap(mine_i, other_i);
  assign sight_hit_o = has_sight_i && overlap(sight_i, other_i);

endmodule

// ===== sv/gbp_checker.sv =====
// ----------------------------------------------------------------------------
// gbp_checker
// Port-level checks of the grid broad-phase block, bound to the top level.
// ----------------------------------------------------------------------------
module gbp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input gbp_pkg::item_t item_i,
  input logic           result_valid_o,
  input gbp_pkg::res_t  result_o
);

  logic accept;
  assign accept = start_i & ~busy_o;

  // a clear answers on the next cycle with a single item
  a_clear_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.cmd == gbp_pkg::CmdClear |=>
      result_valid_o && result_o.last && result_o.status == gbp_pkg::StatCleared)
    else $error("clear not answered");

  // an insert answers on the next cycle with a single item
  a_insert_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.cmd == gbp_pkg::CmdInsert |=>
      result_valid_o && result_o.last &&
      (result_o.status == gbp_pkg::StatInserted ||
       result_o.status == gbp_pkg::StatOutside ||
       result_o.status == gbp_pkg::StatFull))
    else $error("insert not answered");

  // the unused command gives nothing
  a_unused_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.cmd == gbp_pkg::CmdUnused |=> !result_valid_o)
    else $error("result from unused command");

  // an entry is never paired with itself
  a_no_self_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.pair_valid |->
      result_o.placed_index != result_o.other_index)
    else $error("entry paired with itself");

  // more items still to come keep the block busy
  a_busy_midwalk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> busy_o)
    else $error("idle before last item");

endmodule

bind grid_broad_phase_collision_top gbp_checker u_gbp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

// ===== test/gbp_collision_checker.sv =====
// ----------------------------------------------------------------------------
// gbp_collision_checker
// Watches the command, config and result channels of the grid broad-phase
// block, keeps its own copy of the cell store, works out the results each
// accepted item should produce and compares them with what comes out.
// ----------------------------------------------------------------------------
module gbp_collision_checker
  import gbp_pkg::*;
#(
  parameter int unsigned EntriesPerCell = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  item_t       item_i,
  input  logic        result_valid_i,
  input  res_t        result_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          result_cnt_o,
  output int          hit_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [14:0] area_w;
  logic [14:0] area_h;
  int          fill    [4];
  box_t        bodies  [4][EntriesPerCell];
  box_t        sights  [4][EntriesPerCell];
  logic        sees    [4][EntriesPerCell];
  res_t        reports_due [$];

  function automatic res_t mk_res(logic [2:0] st, int cell_no, int idx, int other,
                                  bit pv, bit bh, bit sh, bit lst);
    res_t r;
    r.status       = st;
    r.placed_cell  = cell_no[1:0];
    r.placed_index = idx[3:0];
    r.other_index  = other[3:0];
    r.pair_valid   = pv;
    r.body_hit     = bh;
    r.sight_hit    = sh;
    r.last         = lst;
    return r;
  endfunction

  // strict overlap: shared edges do not count
  function automatic bit boxes_overlap(box_t a, box_t b);
    int ax, ay, bx, by;
    ax = $signed(a.x);
    ay = $signed(a.y);
    bx = $signed(b.x);
    by = $signed(b.y);
    return (ax < bx + int'(b.w)) && (ax + int'(a.w) > bx) &&
           (ay < by + int'(b.h)) && (ay + int'(a.h) > by);
  endfunction

  task automatic predict_grid_cmd(input item_t it);
    int x, y, hw, hh, col, row, cell_no, n, sel, final_other;
    case (it.cmd)
      CmdInsert: begin
        x = $signed(it.body_x);
        y = $signed(it.body_y);
        if (x < 0 || y < 0 || x >= int'(area_w) || y >= int'(area_h)) begin
          reports_due.push_back(mk_res(StatOutside, 0, 0, 0, 0, 0, 0, 1));
        end else begin
          hw = int'(area_w) >> 1;
          hh = int'(area_h) >> 1;
          if (hw == 0) hw = 1;
          if (hh == 0) hh = 1;
          col = x / hw;
          row = y / hh;
          if (col > 1) col = 1;
          if (row > 1) row = 1;
          cell_no = col * 2 + row;
          n = fill[cell_no];
          if (n >= EntriesPerCell) begin
            reports_due.push_back(mk_res(StatFull, cell_no, 0, 0, 0, 0, 0, 1));
          end else begin
            bodies[cell_no][n] = '{it.body_x, it.body_y, it.body_w, it.body_h};
            sights[cell_no][n] = '{it.sight_x, it.sight_y, it.sight_w, it.sight_h};
            sees[cell_no][n]   = it.has_sight;
            fill[cell_no]      = n + 1;
            reports_due.push_back(mk_res(StatInserted, cell_no, n, 0, 0, 0, 0, 1));
          end
        end
      end
      CmdCheck: begin
        cell_no = it.cell_sel;
        sel     = it.entry_sel;
        n       = fill[cell_no];
        if (sel >= n) begin
          reports_due.push_back(mk_res(StatBadIndex, cell_no, sel, 0, 0, 0, 0, 1));
        end else if (n == 1) begin
          reports_due.push_back(mk_res(StatPair, cell_no, sel, 0, 0, 0, 0, 1));
        end else begin
          final_other = (sel == n - 1) ? n - 2 : n - 1;
          for (int i = 0; i < n; i++) begin
            if (i != sel) begin
              reports_due.push_back(mk_res(StatPair, cell_no, sel, i, 1,
                boxes_overlap(bodies[cell_no][sel], bodies[cell_no][i]),
                sees[cell_no][sel] &&
                  boxes_overlap(sights[cell_no][sel], bodies[cell_no][i]),
                i == final_other));
            end
          end
        end
      end
      CmdClear: begin
        fill = '{0, 0, 0, 0};
        reports_due.push_back(mk_res(StatCleared, 0, 0, 0, 0, 0, 0, 1));
      end
      default: ;
    endcase
  endtask

  task automatic cmp_field(input string name, input logic [3:0] want,
                           input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt_o++;
    end
  endtask

  task automatic check_report(input res_t got);
    res_t want;
    if (reports_due.size() == 0) begin
      $error("result with nothing outstanding: status %0d", got.status);
      fail_cnt_o++;
      return;
    end
    want = reports_due.pop_front();
    cmp_field("status",       4'(want.status),       4'(got.status));
    cmp_field("placed_cell",  4'(want.placed_cell),  4'(got.placed_cell));
    cmp_field("placed_index", want.placed_index,     got.placed_index);
    cmp_field("other_index",  want.other_index,      got.other_index);
    cmp_field("pair_valid",   4'(want.pair_valid),   4'(got.pair_valid));
    cmp_field("body_hit",     4'(want.body_hit),     4'(got.body_hit));
    cmp_field("sight_hit",    4'(want.sight_hit),    4'(got.sight_hit));
    cmp_field("last",         4'(want.last),         4'(got.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_w = AreaWidthRst;
      area_h = AreaHeightRst;
      fill   = '{0, 0, 0, 0};
      reports_due.delete();
    end else begin
      // results first: an item accepted at this edge cannot have answered yet
      if (result_valid_i) begin
        result_cnt_o++;
        if (result_i.body_hit === 1'b1 || result_i.sight_hit === 1'b1) hit_cnt_o++;
        check_report(result_i);
      end
      if (start_i && !busy_i) predict_grid_cmd(item_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == RegAreaWidth) area_w = cfg_data_i;
        else area_h = cfg_data_i;
      end
    end
    pending_o = reports_due.size();
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the grid broad-phase block with directed and random command items
// over several area settings, with random gaps between items; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gbp_pkg::*;

  localparam int unsigned EntriesPerCell = 16;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  item_t       item_i;
  logic        result_valid_o;
  res_t        result_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [14:0] cfg_data_i;

  int fail_cnt, pending, result_cnt, hit_cnt;

  logic [14:0] cur_w, cur_h;
  int          cell_fill [4];
  int          cmd_cnt   [4];
  int          settings_cnt;
  bit          no_idle;

  grid_broad_phase_collision_top #(
    .ENTRIES_PER_CELL(EntriesPerCell)
  ) u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i,
    .result_valid_o, .result_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  gbp_collision_checker #(
    .EntriesPerCell(EntriesPerCell)
  ) u_checker (
    .clk_i, .rst_ni, .start_i,
    .busy_i         (busy_o),
    .item_i,
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .result_cnt_o   (result_cnt),
    .hit_cnt_o      (hit_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // rough per-cell occupancy, only used to aim checks at stored entries
  always @(posedge clk_i) begin
    if (result_valid_o) begin
      if (result_o.status == StatInserted)
        cell_fill[result_o.placed_cell] <= cell_fill[result_o.placed_cell] + 1;
      else if (result_o.status == StatCleared)
        cell_fill <= '{0, 0, 0, 0};
    end
  end

  function automatic item_t noise_item();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t mk_insert(int x, int y, int w, int h,
                                      int sx, int sy, int sw, int sh, bit vis);
    item_t it;
    it           = '0;
    it.cmd       = CmdInsert;
    it.body_x    = x[15:0];
    it.body_y    = y[15:0];
    it.body_w    = w[14:0];
    it.body_h    = h[14:0];
    it.sight_x   = sx[15:0];
    it.sight_y   = sy[15:0];
    it.sight_w   = sw[14:0];
    it.sight_h   = sh[14:0];
    it.has_sight = vis;
    return it;
  endfunction

  function automatic item_t mk_check(int cell_no, int sel);
    item_t it;
    it           = '0;
    it.cmd       = CmdCheck;
    it.cell_sel  = cell_no[1:0];
    it.entry_sel = sel[3:0];
    return it;
  endfunction

  function automatic item_t mk_plain(logic [1:0] cmd);
    item_t it;
    it     = noise_item();
    it.cmd = cmd;
    return it;
  endfunction

  function automatic int rand_len();
    case ($urandom_range(0, 9))
      0:       return 0;
      1, 2:    return $urandom_range(0, 32767);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // body corner inside the chosen cell, mostly clustered near its origin
  function automatic item_t rand_insert(int cell_no);
    int hw, hh, xlo, xhi, ylo, yhi, x, y;
    item_t it;
    hw = int'(cur_w) >> 1;
    hh = int'(cur_h) >> 1;
    if (hw == 0) hw = 1;
    if (hh == 0) hh = 1;
    xlo = cell_no[1] ? hw : 0;
    xhi = cell_no[1] ? int'(cur_w) - 1 : hw - 1;
    ylo = cell_no[0] ? hh : 0;
    yhi = cell_no[0] ? int'(cur_h) - 1 : hh - 1;
    if ($urandom_range(0, 4) == 0) begin
      x = $urandom_range(xlo, xhi);
      y = $urandom_range(ylo, yhi);
    end else begin
      x = xlo + $urandom_range(0, (xhi - xlo < 48) ? xhi - xlo : 48);
      y = ylo + $urandom_range(0, (yhi - ylo < 48) ? yhi - ylo : 48);
    end
    it           = noise_item();
    it.cmd       = CmdInsert;
    it.body_x    = x[15:0];
    it.body_y    = y[15:0];
    it.body_w    = 15'(rand_len());
    it.body_h    = 15'(rand_len());
    it.sight_w   = 15'(rand_len());
    it.sight_h   = 15'(rand_len());
    if ($urandom_range(0, 5) != 0) begin
      it.sight_x = 16'(x + $urandom_range(0, 80) - 40);
      it.sight_y = 16'(y + $urandom_range(0, 80) - 40);
    end
    return it;
  endfunction

  function automatic item_t rand_outside();
    item_t it;
    it     = noise_item();
    it.cmd = CmdInsert;
    case ($urandom_range(0, 3))
      0:       it.body_x = 16'(-int'($urandom_range(1, 32768)));
      1:       it.body_y = 16'(-int'($urandom_range(1, 32768)));
      2:       it.body_x = 16'($urandom_range(int'(cur_w), 32767));
      default: it.body_y = 16'($urandom_range(int'(cur_h), 32767));
    endcase
    return it;
  endfunction

  function automatic item_t rand_check();
    int cell_no, sel;
    item_t it;
    cell_no = $urandom_range(0, 3);
    if (cell_fill[cell_no] < 2) cell_no = $urandom_range(0, 3);
    if (cell_fill[cell_no] > 0 && $urandom_range(0, 6) != 0)
      sel = $urandom_range(0, cell_fill[cell_no] - 1);
    else
      sel = $urandom_range(0, 15);
    it           = noise_item();
    it.cmd       = CmdCheck;
    it.cell_sel  = cell_no[1:0];
    it.entry_sel = sel[3:0];
    return it;
  endfunction

  task automatic send(input item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk_i) start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    cmd_cnt[it.cmd]++;
  endtask

  // drop start and let the block drain, allowing for a walk of a full cell
  task automatic wait_quiet();
    @(negedge clk_i) start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (EntriesPerCell + 4) @(negedge clk_i);
  endtask

  task automatic set_area(input logic [14:0] w, input logic [14:0] h);
    wait_quiet();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegAreaWidth;
    cfg_data_i <= w;
    @(negedge clk_i);
    cfg_idx_i  <= RegAreaHeight;
    cfg_data_i <= h;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    cur_w = w;
    cur_h = h;
    settings_cnt++;
  endtask

  task automatic random_run(input int count);
    int done, pick;
    item_t it;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)      it = rand_insert(pick < 20 ? 0 : $urandom_range(0, 3));
      else if (pick < 56) it = rand_outside();
      else if (pick < 92) it = rand_check();
      else if (pick < 95) it = mk_plain(CmdClear);
      else if (pick < 98) it = mk_plain(CmdUnused);
      else                it = noise_item();
      send(it);
      if (it.cmd != CmdUnused) done++;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    item_i       = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = RegAreaWidth;
    cfg_data_i   = '0;
    cur_w        = AreaWidthRst;
    cur_h        = AreaHeightRst;
    settings_cnt = 1;
    no_idle      = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed part, reset area 800 x 600
    send(mk_check(0, 0));
    send(mk_insert(-1, 0, 5, 5, 0, 0, 0, 0, 0));
    send(mk_insert(0, -32768, 5, 5, 0, 0, 0, 0, 0));
    send(mk_insert(800, 10, 5, 5, 0, 0, 0, 0, 0));
    send(mk_insert(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1));
    send(mk_insert(0, 0, 10, 10, 5, 5, 20, 20, 1));
    // shares an edge with the first box; sight still reaches it
    send(mk_insert(10, 0, 10, 10, -32768, -32768, 0, 0, 0));
    send(mk_insert(9, 9, 32767, 32767, 0, 0, 32767, 32767, 1));
    send(mk_insert(399, 299, 0, 0, 399, 299, 0, 0, 1));
    send(mk_insert(400, 0, 20, 20, 390, 0, 30, 30, 1));
    send(mk_insert(0, 300, 20, 20, 0, 290, 30, 30, 1));
    send(mk_insert(799, 599, 32767, 32767, -32768, -32768, 32767, 32767, 1));
    send(mk_check(2, 0));
    send(mk_check(0, 0));
    send(mk_check(0, 1));
    send(mk_check(0, 3));
    send(mk_check(0, 15));
    send(mk_plain(CmdUnused));
    send(mk_plain(CmdClear));
    send(mk_check(3, 0));
    // fill one cell, then one more to overflow it
    for (int i = 0; i <= EntriesPerCell; i++)
      send(mk_insert(600 + i * 11, 450 + i * 7, 30, 30, 580 + i * 11, 430, 60, 60, i[0]));
    send(mk_check(3, 15));
    send(mk_check(3, 0));

    random_run(40);
    set_area(15'd2, 15'd32767);
    random_run(40);
    no_idle = 1'b1;
    set_area(15'd32767, 15'd2);
    random_run(40);
    no_idle = 1'b0;
    set_area(15'd3, 15'd5);
    random_run(40);
    set_area(15'($urandom_range(2, 32767)), 15'($urandom_range(2, 32767)));
    random_run(40);

    wait_quiet();
    $display("Covered %0d inserts, %0d checks, %0d clears, %0d ignored items, %0d areas.",
             cmd_cnt[CmdInsert], cmd_cnt[CmdCheck], cmd_cnt[CmdClear],
             cmd_cnt[CmdUnused], settings_cnt);
    $display("Compared %0d results, %0d with a body or sight hit.", result_cnt, hit_cnt);
    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
